// File: rtl/ridtbl_pkg.sv
`default_nettype none

package ridtbl_pkg;

	// table geometry and field widths
	localparam int DEPTH    = 256;
	localparam int POS_W    = $clog2(DEPTH);
	localparam int CNT_W    = POS_W + 1;
	localparam int ID_W     = 32;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 3;

	// operation codes on the mode field
	typedef enum logic [MODE_W-1:0] {
		MODE_ADD     = 2'd0,
		MODE_LOOKUP  = 2'd1,
		MODE_DELETE  = 2'd2,
		MODE_COMPACT = 2'd3
	} mode_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 3'd0,
		STS_NOT_FOUND = 3'd1,
		STS_FULL      = 3'd2,
		STS_BAD_POS   = 3'd3,
		STS_EXHAUSTED = 3'd4
	} status_t;

	// which result goes into the output register
	typedef enum logic [2:0] {
		RES_DONE,
		RES_ADDED,
		RES_FOUND,
		RES_NOT_FOUND,
		RES_FULL,
		RES_BAD_POS,
		RES_EXHAUSTED
	} res_sel_t;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD,
		S_DEL,
		S_LK_START,
		S_LK_RD,
		S_LK_CMP,
		S_CP_RD,
		S_CP_WR
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic     latch;
		logic     add_do;
		logic     del_do;
		logic     lk_init;
		logic     rd_issue;
		logic     ptr_dec;
		logic     ptr_inc;
		logic     cp_init;
		logic     cp_move;
		logic     cp_finish;
		logic     res_load;
		res_sel_t res_sel;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic full;
		logic exhausted;
		logic key_zero;
		logic empty;
		logic del_bad;
		logic hit;
		logic below;
		logic at_zero;
		logic cp_end;
		logic cp_live;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// File: rtl/ridtbl_ctrl.sv
`default_nettype none

module ridtbl_ctrl (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic [ridtbl_pkg::MODE_W-1:0]   mode,
	output logic                                 in_stall,
	input  wire ridtbl_pkg::sts_t                sts,
	output ridtbl_pkg::cmd_t                     cmd
);

	ridtbl_pkg::state_t state_q;
	ridtbl_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ridtbl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.res_sel = ridtbl_pkg::RES_DONE;
		in_stall    = (state_q != ridtbl_pkg::S_IDLE);
		unique case (state_q)
			ridtbl_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					unique case (ridtbl_pkg::mode_t'(mode))
						ridtbl_pkg::MODE_ADD:    state_d = ridtbl_pkg::S_ADD;
						ridtbl_pkg::MODE_LOOKUP: state_d = ridtbl_pkg::S_LK_START;
						ridtbl_pkg::MODE_DELETE: state_d = ridtbl_pkg::S_DEL;
						ridtbl_pkg::MODE_COMPACT: begin
							cmd.cp_init = 1'b1;
							state_d     = ridtbl_pkg::S_CP_RD;
						end
						default: state_d = ridtbl_pkg::S_IDLE;
					endcase
				end
			end
			// append a row, full takes precedence over exhaustion
			ridtbl_pkg::S_ADD: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = ridtbl_pkg::S_IDLE;
					priority if (sts.full) begin
						cmd.res_sel = ridtbl_pkg::RES_FULL;
					end else if (sts.exhausted) begin
						cmd.res_sel = ridtbl_pkg::RES_EXHAUSTED;
					end else begin
						cmd.add_do  = 1'b1;
						cmd.res_sel = ridtbl_pkg::RES_ADDED;
					end
				end
			end
			// tombstone one row
			ridtbl_pkg::S_DEL: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = ridtbl_pkg::S_IDLE;
					if (sts.del_bad) begin
						cmd.res_sel = ridtbl_pkg::RES_BAD_POS;
					end else begin
						cmd.del_do  = 1'b1;
						cmd.res_sel = ridtbl_pkg::RES_DONE;
					end
				end
			end
			// no key or empty table answers at once
			ridtbl_pkg::S_LK_START: begin
				if (sts.key_zero || sts.empty) begin
					if (sts.out_free) begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = ridtbl_pkg::RES_NOT_FOUND;
						state_d      = ridtbl_pkg::S_IDLE;
					end
				end else begin
					cmd.lk_init = 1'b1;
					state_d     = ridtbl_pkg::S_LK_RD;
				end
			end
			ridtbl_pkg::S_LK_RD: begin
				cmd.rd_issue = 1'b1;
				state_d      = ridtbl_pkg::S_LK_CMP;
			end
			// downward scan step
			ridtbl_pkg::S_LK_CMP: begin
				priority if (sts.hit) begin
					if (sts.out_free) begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = ridtbl_pkg::RES_FOUND;
						state_d      = ridtbl_pkg::S_IDLE;
					end
				end else if (sts.below || sts.at_zero) begin
					if (sts.out_free) begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = ridtbl_pkg::RES_NOT_FOUND;
						state_d      = ridtbl_pkg::S_IDLE;
					end
				end else begin
					cmd.ptr_dec = 1'b1;
					state_d     = ridtbl_pkg::S_LK_RD;
				end
			end
			// compaction read side, dead rows skipped without an id memory read
			ridtbl_pkg::S_CP_RD: begin
				priority if (sts.cp_end) begin
					if (sts.out_free) begin
						cmd.cp_finish = 1'b1;
						cmd.res_load  = 1'b1;
						cmd.res_sel   = ridtbl_pkg::RES_DONE;
						state_d       = ridtbl_pkg::S_IDLE;
					end
				end else if (sts.cp_live) begin
					cmd.rd_issue = 1'b1;
					state_d      = ridtbl_pkg::S_CP_WR;
				end else begin
					cmd.ptr_inc = 1'b1;
				end
			end
			ridtbl_pkg::S_CP_WR: begin
				cmd.cp_move = 1'b1;
				state_d     = ridtbl_pkg::S_CP_RD;
			end
			default: state_d = ridtbl_pkg::S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/ridtbl_dp.sv
`default_nettype none

module ridtbl_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ridtbl_pkg::cmd_t                  cmd,
	output ridtbl_pkg::sts_t                       sts,
	input  wire logic [ridtbl_pkg::ID_W-1:0]       key_id,
	input  wire logic [ridtbl_pkg::POS_W-1:0]      hint_pos,
	input  wire logic                              hint_valid,
	input  wire logic [ridtbl_pkg::POS_W-1:0]      delete_pos,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [ridtbl_pkg::STATUS_W-1:0]        status,
	output logic [ridtbl_pkg::ID_W-1:0]            result_id,
	output logic [ridtbl_pkg::POS_W-1:0]           result_pos,
	output logic [ridtbl_pkg::CNT_W-1:0]           row_count
);

	localparam int PW = ridtbl_pkg::POS_W;
	localparam int CW = ridtbl_pkg::CNT_W;
	localparam int IW = ridtbl_pkg::ID_W;

	// latched request
	logic [IW-1:0] key_q;
	logic [PW-1:0] hint_q;
	logic          hint_ok_q;
	logic [PW-1:0] del_q;

	// table state
	logic [IW-1:0]                  row_ids [ridtbl_pkg::DEPTH];
	logic [ridtbl_pkg::DEPTH-1:0]   live_q;
	logic [CW-1:0]                  used_q;
	logic [IW-1:0]                  next_id_q;

	// scan pointers and read side
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] wr_q;
	logic [IW-1:0] rdata_q;
	logic          rlive_q;

	// output register
	logic                    out_valid_q;
	ridtbl_pkg::status_t     status_q;
	logic [IW-1:0]           result_id_q;
	logic [PW-1:0]           result_pos_q;
	logic [CW-1:0]           row_count_q;

	logic [CW-1:0] used_m1;
	logic [CW-1:0] hint_ext;
	logic [CW-1:0] start;
	logic [CW-1:0] used_nx;
	logic          out_free;

	// scan start: last row, or the hint when it lies below it
	always_comb begin
		used_m1  = used_q - CW'(1);
		hint_ext = {1'b0, hint_q};
		start    = (hint_ok_q && (hint_ext < used_m1)) ? hint_ext : used_m1;
	end

	always_comb begin
		used_nx = used_q;
		if (cmd.add_do) begin
			used_nx = used_q + CW'(1);
		end else if (cmd.cp_finish) begin
			used_nx = wr_q;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	// status towards the controller
	always_comb begin
		sts.full      = (used_q == CW'(ridtbl_pkg::DEPTH));
		sts.exhausted = (next_id_q == '0);
		sts.key_zero  = (key_q == '0);
		sts.empty     = (used_q == '0);
		sts.del_bad   = ({1'b0, del_q} >= used_q);
		sts.hit       = rlive_q && (rdata_q == key_q);
		sts.below     = rlive_q && (rdata_q < key_q);
		sts.at_zero   = (ptr_q == '0);
		sts.cp_end    = (ptr_q == used_q);
		sts.cp_live   = live_q[ptr_q[PW-1:0]];
		sts.out_free  = out_free;
	end

	// request capture on the input transfer
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			key_q     <= key_id;
			hint_q    <= hint_pos;
			hint_ok_q <= hint_valid;
			del_q     <= delete_pos;
		end
	end

	// id memory write port: append or compaction move
	always_ff @(posedge clk) begin
		if (cmd.add_do) begin
			row_ids[used_q[PW-1:0]] <= next_id_q;
		end else if (cmd.cp_move) begin
			row_ids[wr_q[PW-1:0]] <= rdata_q;
		end
	end

	// id memory read port, registered, with the live bit alongside
	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			rdata_q <= row_ids[ptr_q[PW-1:0]];
			rlive_q <= live_q[ptr_q[PW-1:0]];
		end
	end

	// live bits, count and id counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q    <= '0;
			used_q    <= '0;
			next_id_q <= IW'(1);
		end else begin
			if (cmd.add_do) begin
				live_q[used_q[PW-1:0]] <= 1'b1;
				next_id_q              <= next_id_q + IW'(1);
			end
			if (cmd.del_do) begin
				live_q[del_q] <= 1'b0;
			end
			// clear source first so an in-place move stays live
			if (cmd.cp_move) begin
				live_q[ptr_q[PW-1:0]] <= 1'b0;
				live_q[wr_q[PW-1:0]]  <= 1'b1;
			end
			used_q <= used_nx;
		end
	end

	// scan and compaction pointers
	always_ff @(posedge clk) begin
		if (cmd.cp_init) begin
			ptr_q <= '0;
			wr_q  <= '0;
		end else begin
			if (cmd.lk_init) begin
				ptr_q <= start;
			end else if (cmd.ptr_dec) begin
				ptr_q <= ptr_q - CW'(1);
			end else if (cmd.ptr_inc || cmd.cp_move) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (cmd.cp_move) begin
				wr_q <= wr_q + CW'(1);
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			row_count_q  <= used_nx;
			result_id_q  <= '0;
			result_pos_q <= '0;
			unique case (cmd.res_sel)
				ridtbl_pkg::RES_DONE:      status_q <= ridtbl_pkg::STS_OK;
				ridtbl_pkg::RES_ADDED: begin
					status_q     <= ridtbl_pkg::STS_OK;
					result_id_q  <= next_id_q;
					result_pos_q <= used_q[PW-1:0];
				end
				ridtbl_pkg::RES_FOUND: begin
					status_q     <= ridtbl_pkg::STS_OK;
					result_id_q  <= key_q;
					result_pos_q <= ptr_q[PW-1:0];
				end
				ridtbl_pkg::RES_NOT_FOUND: status_q <= ridtbl_pkg::STS_NOT_FOUND;
				ridtbl_pkg::RES_FULL:      status_q <= ridtbl_pkg::STS_FULL;
				ridtbl_pkg::RES_BAD_POS:   status_q <= ridtbl_pkg::STS_BAD_POS;
				ridtbl_pkg::RES_EXHAUSTED: status_q <= ridtbl_pkg::STS_EXHAUSTED;
				default:                   status_q <= ridtbl_pkg::STS_OK;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign result_id  = result_id_q;
	assign result_pos = result_pos_q;
	assign row_count  = row_count_q;

endmodule

`default_nettype wire

// File: rtl/row_id_table_hinted_lookup.sv
`default_nettype none

// channel  handshake             fields
// input    in_valid, in_stall    mode, key_id, hint_pos, hint_valid, delete_pos
// output   out_valid, out_stall  status, result_id, result_pos, row_count
//
// add and delete: the S_ADD or S_DEL state loads the result once the output register is free.
// lookup: S_LK_RD and S_LK_CMP alternate per row visited; compact: a dead row is stepped over
// in S_CP_RD, a live row is read in S_CP_RD and moved in S_CP_WR. each visited lookup row and
// each moved row uses the single read port of the id memory, with registered read data.
// reset clears the live bits and the row count and sets the next id to 1; no
// clearing pass. in_stall is high from a transfer until its result is loaded;
// a waiting result holds in the output register while out_stall is high.

module row_id_table_hinted_lookup (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [ridtbl_pkg::MODE_W-1:0]       mode,
	input  wire logic [ridtbl_pkg::ID_W-1:0]         key_id,
	input  wire logic [ridtbl_pkg::POS_W-1:0]        hint_pos,
	input  wire logic                                hint_valid,
	input  wire logic [ridtbl_pkg::POS_W-1:0]        delete_pos,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [ridtbl_pkg::STATUS_W-1:0]          status,
	output logic [ridtbl_pkg::ID_W-1:0]              result_id,
	output logic [ridtbl_pkg::POS_W-1:0]             result_pos,
	output logic [ridtbl_pkg::CNT_W-1:0]             row_count
);

	ridtbl_pkg::cmd_t cmd;
	ridtbl_pkg::sts_t sts;

	// sequencer
	ridtbl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table storage and result register
	ridtbl_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.key_id     (key_id),
		.hint_pos   (hint_pos),
		.hint_valid (hint_valid),
		.delete_pos (delete_pos),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.result_id  (result_id),
		.result_pos (result_pos),
		.row_count  (row_count)
	);

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> sts.out_free)
		else $error("result loaded over a pending transfer");

	// append only with room and ids left
	a_add_legal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_do |-> (!sts.full && !sts.exhausted))
		else $error("append on full table or exhausted ids");

	// block is busy in the cycle after an input transfer
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |=> in_stall)
		else $error("input taken without going busy");

endmodule

`default_nettype wire
